[rtl/mpfte_pkg.sv]
// Package of shared types and constants for the page framebuffer text engine.
`timescale 1ns / 1ps
package mpfte_pkg;

    localparam logic [2:0] OP_CLEAR  = 3'd0;
    localparam logic [2:0] OP_PIXEL  = 3'd1;
    localparam logic [2:0] OP_CURSOR = 3'd2;
    localparam logic [2:0] OP_CHAR   = 3'd3;
    localparam logic [2:0] OP_GLYPH  = 3'd4;
    localparam logic [2:0] OP_READ   = 3'd5;
    localparam logic [2:0] OP_SPARE6 = 3'd6;
    localparam logic [2:0] OP_SPARE7 = 3'd7;

    localparam logic [1:0] CFG_FONT_WIDTH   = 2'd0;
    localparam logic [1:0] CFG_FONT_HEIGHT  = 2'd1;
    localparam logic [1:0] CFG_FONT_PRESENT = 2'd2;

    localparam logic [7:0] FIRST_CODE = 8'd32;
    localparam logic [7:0] LAST_CODE  = 8'd126;

    typedef enum logic [3:0] {
        ST_INIT_CLR,
        ST_IDLE,
        ST_CLEAR,
        ST_PIX_RD,
        ST_PIX_WAIT,
        ST_PIX_WR,
        ST_GLY_RD,
        ST_GLY_WAIT,
        ST_COL_RD,
        ST_COL_WAIT,
        ST_COL_WR,
        ST_READ_WAIT,
        ST_READ_CAP,
        ST_DONE
    } t_state;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load_cmd;    // capture the input transfer
        logic clr_start;   // zero the clear address
        logic clr_write;   // write fill byte, step address
        logic fb_wr;       // write modified frame byte
        logic col_start;   // zero the column counter
        logic col_step;    // step column
        logic row_step;    // step row, zero column
        logic cursor_set;  // cursor from command
        logic cursor_adv;  // advance cursor by font width
        logic res_load;    // compute and hold the result
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic       clr_last;
        logic       pix_ok;
        logic       char_ok;
        logic       col_last;
        logic       row_last;
        logic [2:0] op;
    } t_stat;

endpackage

[rtl/mpfte_ctrl.sv]
// Controller state machine sequencing commands of the text engine.
`timescale 1ns / 1ps
module mpfte_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  mpfte_pkg::t_stat     i_stat,
    output mpfte_pkg::t_cmd      o_cmd
);

    mpfte_pkg::t_state r_state, n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mpfte_pkg::ST_INIT_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            mpfte_pkg::ST_INIT_CLR: begin
                o_cmd.clr_write = 1'b1;
                if (i_stat.clr_last) n_state = mpfte_pkg::ST_IDLE;
            end
            mpfte_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_cmd = 1'b1;
                    o_cmd.clr_start = 1'b1;
                    n_state = mpfte_pkg::ST_DONE;
                    case (i_stat.op)
                        mpfte_pkg::OP_CLEAR:  n_state = mpfte_pkg::ST_CLEAR;
                        mpfte_pkg::OP_PIXEL:  n_state = mpfte_pkg::ST_PIX_RD;
                        mpfte_pkg::OP_CHAR:   n_state = mpfte_pkg::ST_GLY_RD;
                        mpfte_pkg::OP_READ:   n_state = mpfte_pkg::ST_READ_WAIT;
                        default:              n_state = mpfte_pkg::ST_DONE;
                    endcase
                end
            end
            mpfte_pkg::ST_CLEAR: begin
                o_cmd.clr_write = 1'b1;
                if (i_stat.clr_last) begin
                    o_cmd.res_load = 1'b1;
                    n_state = mpfte_pkg::ST_DONE;
                end
            end
            mpfte_pkg::ST_PIX_RD: begin
                o_cmd.res_load = 1'b1;
                if (i_stat.pix_ok) begin
                    n_state = mpfte_pkg::ST_PIX_WAIT;
                end else begin
                    n_state = mpfte_pkg::ST_DONE;
                end
            end
            mpfte_pkg::ST_PIX_WAIT: n_state = mpfte_pkg::ST_PIX_WR;
            mpfte_pkg::ST_PIX_WR: begin
                o_cmd.fb_wr = 1'b1;
                n_state = mpfte_pkg::ST_DONE;
            end
            mpfte_pkg::ST_GLY_RD: begin
                o_cmd.col_start = 1'b1;
                if (i_stat.char_ok) begin
                    n_state = mpfte_pkg::ST_GLY_WAIT;
                end else begin
                    o_cmd.res_load = 1'b1;
                    n_state = mpfte_pkg::ST_DONE;
                end
            end
            mpfte_pkg::ST_GLY_WAIT: n_state = mpfte_pkg::ST_COL_RD;
            mpfte_pkg::ST_COL_RD: n_state = mpfte_pkg::ST_COL_WAIT;
            mpfte_pkg::ST_COL_WAIT: n_state = mpfte_pkg::ST_COL_WR;
            mpfte_pkg::ST_COL_WR: begin
                o_cmd.fb_wr = 1'b1;
                if (!i_stat.col_last) begin
                    o_cmd.col_step = 1'b1;
                    n_state = mpfte_pkg::ST_COL_RD;
                end else if (!i_stat.row_last) begin
                    o_cmd.row_step = 1'b1;
                    n_state = mpfte_pkg::ST_GLY_WAIT;
                end else begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.cursor_adv = 1'b1;
                    n_state = mpfte_pkg::ST_DONE;
                end
            end
            mpfte_pkg::ST_READ_WAIT: n_state = mpfte_pkg::ST_READ_CAP;
            mpfte_pkg::ST_READ_CAP: begin
                o_cmd.res_load = 1'b1;
                n_state = mpfte_pkg::ST_DONE;
            end
            mpfte_pkg::ST_DONE: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = mpfte_pkg::ST_IDLE;
            end
            default: n_state = mpfte_pkg::ST_IDLE;
        endcase
        // Quick commands finish in the accept cycle's result load.
        if (r_state == mpfte_pkg::ST_IDLE && i_in_valid &&
            (i_stat.op inside {mpfte_pkg::OP_CURSOR, mpfte_pkg::OP_GLYPH,
                               mpfte_pkg::OP_SPARE6, mpfte_pkg::OP_SPARE7})) begin
            o_cmd.res_load = 1'b1;
            o_cmd.cursor_set = (i_stat.op == mpfte_pkg::OP_CURSOR);
        end
    end

endmodule

[rtl/mpfte_dp.sv]
// Datapath: frame store, glyph store, cursor, font registers and result.
`timescale 1ns / 1ps
module mpfte_dp #(
    parameter int DISPLAY_WIDTH   = 128,
    parameter int DISPLAY_HEIGHT  = 64,
    parameter int MAX_FONT_HEIGHT = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mpfte_pkg::t_cmd  i_cmd,
    output mpfte_pkg::t_stat o_stat,
    input  logic             i_cfg_valid,
    input  logic [1:0]       i_cfg_index,
    input  logic [5:0]       i_cfg_data,
    input  logic [2:0]       i_op,
    input  logic [8:0]       i_x,
    input  logic [8:0]       i_y,
    input  logic             i_color,
    input  logic [7:0]       i_char_code,
    input  logic [11:0]      i_glyph_addr,
    input  logic [15:0]      i_glyph_bits,
    input  logic [9:0]       i_read_addr,
    output logic             o_accepted,
    output logic [7:0]       o_char_echo,
    output logic [7:0]       o_read_data
);

    localparam int PAGE_COUNT  = (DISPLAY_HEIGHT + 7) / 8;
    localparam int FRAME_BYTES = DISPLAY_WIDTH * PAGE_COUNT;
    localparam int FA_W        = $clog2(FRAME_BYTES);
    localparam int GLYPH_DEPTH = 95 * MAX_FONT_HEIGHT;
    localparam int GA_W        = $clog2(GLYPH_DEPTH);

    logic [7:0]  r_fb [FRAME_BYTES];
    logic [15:0] r_gs [GLYPH_DEPTH];

    logic [4:0]  r_font_width;
    logic [5:0]  r_font_height;
    logic        r_font_present;
    logic [8:0]  r_cur_col, r_cur_row;

    logic [2:0]  r_op;
    logic [8:0]  r_x, r_y;
    logic        r_color;
    logic [7:0]  r_code;
    logic [9:0]  r_raddr;

    logic [FA_W-1:0] r_clr_addr;
    logic [3:0]  r_col;
    logic [4:0]  r_row;
    logic [11:0] r_gbase;
    logic [15:0] r_gq;
    logic [7:0]  r_fq;
    logic        r_init_fill;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_font_width   <= 5'd8;
            r_font_height  <= 6'd16;
            r_font_present <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mpfte_pkg::CFG_FONT_WIDTH:   r_font_width   <= i_cfg_data[4:0];
                mpfte_pkg::CFG_FONT_HEIGHT:  r_font_height  <= i_cfg_data;
                mpfte_pkg::CFG_FONT_PRESENT: r_font_present <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Command capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_cmd) begin
            r_op    <= i_op;
            r_x     <= i_x;
            r_y     <= i_y;
            r_color <= i_color;
            r_code  <= i_char_code;
            r_raddr <= i_read_addr;
        end
    end

    // Draw geometry and checks.
    logic [9:0]  col_end, row_end;
    logic        char_ok;
    logic [8:0]  px, py;
    logic [FA_W-1:0] waddr;
    logic        pix_ok;
    logic [7:0]  mask, wbyte;
    logic        bit_val;
    logic [11:0] gidx;
    logic        read_ok;

    assign col_end = {1'b0, r_cur_col} + {5'd0, r_font_width};
    assign row_end = {1'b0, r_cur_row} + {4'd0, r_font_height};
    assign char_ok = r_font_present && r_code >= mpfte_pkg::FIRST_CODE &&
                     r_code <= mpfte_pkg::LAST_CODE && r_font_width != 5'd0 &&
                     r_font_width <= 5'd16 && r_font_height != 6'd0 &&
                     r_font_height <= 6'(MAX_FONT_HEIGHT) &&
                     col_end <= 10'(DISPLAY_WIDTH) && row_end <= 10'(DISPLAY_HEIGHT);

    assign px = (r_op == mpfte_pkg::OP_CHAR) ? 9'(r_cur_col + {5'd0, r_col}) : r_x;
    assign py = (r_op == mpfte_pkg::OP_CHAR) ? 9'(r_cur_row + {4'd0, r_row}) : r_y;
    assign pix_ok = (px < 9'(DISPLAY_WIDTH)) && (py < 9'(DISPLAY_HEIGHT));
    assign waddr  = FA_W'({3'd0, px} + {3'd0, py[8:3]} * 12'(DISPLAY_WIDTH));
    assign mask   = 8'd1 << py[2:0];
    // A set glyph bit takes the colour, a clear one the inverse colour.
    assign bit_val = (r_op == mpfte_pkg::OP_CHAR) ? (r_gq[4'd15 - r_col] ~^ r_color)
                                                 : r_color;
    assign wbyte  = bit_val ? (r_fq | mask) : (r_fq & ~mask);
    assign gidx   = r_gbase + {7'd0, r_row};
    assign read_ok = int'(r_raddr) < FRAME_BYTES;

    // Glyph base (code - 32) * height, one multiply registered on col_start.
    always_ff @(posedge i_clk) begin
        if (i_cmd.col_start)
            r_gbase <= {4'd0, 8'(r_code - mpfte_pkg::FIRST_CODE)} * {6'd0, r_font_height};
    end

    // Row and column counters.
    always_ff @(posedge i_clk) begin
        if (i_cmd.col_start) begin
            r_col <= 4'd0;
            r_row <= 5'd0;
        end else if (i_cmd.row_step) begin
            r_col <= 4'd0;
            r_row <= r_row + 5'd1;
        end else if (i_cmd.col_step) begin
            r_col <= r_col + 4'd1;
        end
    end

    // Cursor.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_col <= 9'd0;
            r_cur_row <= 9'd0;
        end else if (i_cmd.cursor_set) begin
            r_cur_col <= i_x;
            r_cur_row <= i_y;
        end else if (i_cmd.cursor_adv) begin
            r_cur_col <= r_cur_col + {4'd0, r_font_width};
        end
    end

    // Clear sweep address; the first sweep after reset fills with zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_init_fill <= 1'b1;
        end else if (i_cmd.clr_start) begin
            r_clr_addr  <= '0;
            r_init_fill <= 1'b0;
        end else if (i_cmd.clr_write) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // Frame store: one write port, one registered read port.
    logic [FA_W-1:0] fb_raddr;
    assign fb_raddr = (r_op == mpfte_pkg::OP_READ) ? FA_W'(r_raddr) : waddr;
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_write)
            r_fb[r_clr_addr] <= (r_color && !r_init_fill) ? 8'hFF : 8'h00;
        else if (i_cmd.fb_wr && pix_ok)
            r_fb[waddr] <= wbyte;
        r_fq <= r_fb[fb_raddr];
    end

    // Glyph store.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_cmd && i_op == mpfte_pkg::OP_GLYPH &&
            i_glyph_addr < 12'(GLYPH_DEPTH))
            r_gs[GA_W'(i_glyph_addr)] <= i_glyph_bits;
        r_gq <= r_gs[GA_W'(gidx)];
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            o_char_echo <= 8'd0;
            o_read_data <= 8'd0;
            o_accepted  <= 1'b0;
            case (i_cmd.load_cmd ? i_op : r_op)
                mpfte_pkg::OP_CLEAR:  o_accepted <= 1'b1;
                mpfte_pkg::OP_PIXEL:  o_accepted <= pix_ok;
                mpfte_pkg::OP_CURSOR: o_accepted <= 1'b1;
                mpfte_pkg::OP_CHAR: begin
                    o_accepted  <= char_ok;
                    o_char_echo <= char_ok ? r_code : 8'd0;
                end
                mpfte_pkg::OP_GLYPH:  o_accepted <= i_glyph_addr < 12'(GLYPH_DEPTH);
                mpfte_pkg::OP_READ: begin
                    o_accepted  <= read_ok;
                    o_read_data <= read_ok ? r_fq : 8'd0;
                end
                default: o_accepted <= 1'b0;
            endcase
        end
    end

    // Status.
    assign o_stat.clr_last = (r_clr_addr == FA_W'(FRAME_BYTES - 1));
    assign o_stat.pix_ok   = pix_ok;
    assign o_stat.char_ok  = char_ok;
    assign o_stat.col_last = ({1'b0, r_col} == r_font_width - 5'd1);
    assign o_stat.row_last = ({1'b0, r_row} == r_font_height - 6'd1);
    assign o_stat.op       = i_op;

endmodule

[rtl/mono_page_framebuffer_text_engine.sv]
// Top level of the page framebuffer text engine.
// One item at a time; the next transfer is taken after the result is taken.
// After reset the frame store is zeroed by a sweep over all FRAME_BYTES bytes
// (1024 by default) during which no item is accepted; config is always taken.
`timescale 1ns / 1ps
module mono_page_framebuffer_text_engine #(
    parameter int DISPLAY_WIDTH   = 128,
    parameter int DISPLAY_HEIGHT  = 64,
    parameter int MAX_FONT_HEIGHT = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_op,
    input  logic [8:0]  i_x,
    input  logic [8:0]  i_y,
    input  logic        i_color,
    input  logic [7:0]  i_char_code,
    input  logic [11:0] i_glyph_addr,
    input  logic [15:0] i_glyph_bits,
    input  logic [9:0]  i_read_addr,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_accepted,
    output logic [7:0]  o_char_echo,
    output logic [7:0]  o_read_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [5:0]  i_cfg_data
);

    mpfte_pkg::t_cmd  cmd;
    mpfte_pkg::t_stat stat;

    assign o_cfg_ready = 1'b1;

    mpfte_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    mpfte_dp #(
        .DISPLAY_WIDTH   (DISPLAY_WIDTH),
        .DISPLAY_HEIGHT  (DISPLAY_HEIGHT),
        .MAX_FONT_HEIGHT (MAX_FONT_HEIGHT)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_op         (i_op),
        .i_x          (i_x),
        .i_y          (i_y),
        .i_color      (i_color),
        .i_char_code  (i_char_code),
        .i_glyph_addr (i_glyph_addr),
        .i_glyph_bits (i_glyph_bits),
        .i_read_addr  (i_read_addr),
        .o_accepted   (o_accepted),
        .o_char_echo  (o_char_echo),
        .o_read_data  (o_read_data)
    );

endmodule
